// ===== design/gdtm_pkg.sv =====
// Shared types and constants for the glow downsample and tone map block.
package gdtm_pkg;

	localparam int PIX_W      = 8;
	localparam int CH_N       = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 11;
	localparam int SIZE_W     = 11;
	localparam int QUOT_W     = 8;
	localparam int MAG_W      = 2 * PIX_W;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KNEE_LEVEL   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_START    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LOW_END      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_START   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_END     = 3'd6;

	localparam logic [SIZE_W-1:0] RST_FRAME_WIDTH  = 11'd400;
	localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 11'd240;
	localparam logic [PIX_W-1:0]  RST_KNEE_LEVEL   = 8'd192;
	localparam logic [PIX_W-1:0]  RST_LOW_START    = 8'd0;
	localparam logic [PIX_W-1:0]  RST_LOW_END      = 8'd64;
	localparam logic [PIX_W-1:0]  RST_HIGH_START   = 8'd64;
	localparam logic [PIX_W-1:0]  RST_HIGH_END     = 8'd128;

	localparam logic [PIX_W-1:0]  PIX_MAX  = 8'd255;
	localparam logic [SIZE_W-1:0] MIN_SIZE = 11'd2;

	// One pixel, channel 0 in the low byte.
	typedef logic [CH_N-1:0][PIX_W-1:0] pix_t;

	// Operands handed to one divider lane.
	typedef struct packed {
		logic [MAG_W-1:0] mag;
		logic [PIX_W-1:0] den;
	} curve_op_t;

endpackage

// ===== design/gdtm_if.sv =====
// Handshake interfaces for pixel input, result output and configuration writes.
interface gdtm_pix_if;
	import gdtm_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] in_ch0;
	logic [PIX_W-1:0] in_ch1;
	logic [PIX_W-1:0] in_ch2;
	modport source (output valid, output in_ch0, output in_ch1, output in_ch2, input ready);
	modport sink   (input valid, input in_ch0, input in_ch1, input in_ch2, output ready);
endinterface

interface gdtm_res_if;
	import gdtm_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_ch0;
	logic [PIX_W-1:0] out_ch1;
	logic [PIX_W-1:0] out_ch2;
	logic             row_end;
	logic             frame_end;
	modport source (output valid, output out_ch0, output out_ch1, output out_ch2,
		output row_end, output frame_end, input ready);
	modport sink   (input valid, input out_ch0, input out_ch1, input out_ch2,
		input row_end, input frame_end, output ready);
endinterface

interface gdtm_cfg_if;
	import gdtm_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/gdtm_line_store.sv =====
// Half-line store: single-port synchronous RAM with a registered read.
module gdtm_line_store #(
	parameter int DEPTH = 512,
	parameter int AW    = 9
) (
	input  logic           clk,
	input  logic           en,
	input  logic           we,
	input  logic [AW-1:0]  addr,
	input  gdtm_pkg::pix_t wdata,
	output gdtm_pkg::pix_t rdata
);
	import gdtm_pkg::*;

	pix_t mem [DEPTH];
	pix_t rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/gdtm_div.sv =====
// Restoring divider lane that produces an 8-bit quotient, one bit per cycle.
module gdtm_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  gdtm_pkg::curve_op_t      op,
	output logic                     done,
	output logic [gdtm_pkg::QUOT_W-1:0] quot
);
	import gdtm_pkg::*;

	localparam int CNT_W = $clog2(QUOT_W);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [PIX_W-1:0] rem_q;
	logic [PIX_W-1:0] dvd_q;
	logic [PIX_W-1:0] den_q;
	logic [QUOT_W-1:0] quot_q;

	logic [PIX_W:0]   trial;
	logic [PIX_W:0]   trial_sub;
	logic             fits;
	logic [PIX_W-1:0] rem_next;

	// The upper dividend byte is always below the divisor, so only eight steps remain.
	always_comb begin
		trial     = {rem_q, dvd_q[PIX_W-1]};
		trial_sub = trial - {1'b0, den_q};
		fits      = trial >= {1'b0, den_q};
		rem_next  = fits ? trial_sub[PIX_W-1:0] : trial[PIX_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CNT_W'(QUOT_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= op.mag[MAG_W-1:PIX_W];
			dvd_q <= op.mag[PIX_W-1:0];
			den_q <= op.den;
		end else if (busy_q) begin
			rem_q  <= rem_next;
			dvd_q  <= {dvd_q[PIX_W-2:0], 1'b0};
			quot_q <= {quot_q[QUOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

// ===== design/glow_downsample_tone_map.sv =====
// Top level: 2x2 box downsample through a half-line RAM, then a two-segment tone curve.
//
//   port     role    transfer moves
//   -------  ------  ------------------------------------------------------
//   pixel    sink    one input pixel: in_ch0, in_ch1, in_ch2
//   result   source  one half-resolution pixel: out_ch0..2, row_end, frame_end
//   cfg      sink    one register write: index, data (always ready)
//
// An input pixel on an even row or an even column leaves the block ready for the next
// one. The odd-column pixel of an odd row holds off the next transfer while the block
// reads the half-line RAM, forms the curve operands, runs the bit-serial divider lanes
// and then loads the output register once that register is free.
// Reset is asynchronous and active low; it restores the register defaults and
// clears the counters. The half-line RAM is not cleared. A result waiting in the
// output register does not block input; only a finished division waits for it.
module glow_downsample_tone_map #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic       clk,
	input  logic       arst_n,
	gdtm_pix_if.sink   pixel,
	gdtm_res_if.source result,
	gdtm_cfg_if.sink   cfg
);
	import gdtm_pkg::*;

	localparam int HALF_DEPTH = MAX_WIDTH / 2;
	localparam int AW = (HALF_DEPTH > 1) ? $clog2(HALF_DEPTH) : 1;
	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_DIV
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [SIZE_W-1:0] width_q;
	logic [SIZE_W-1:0] height_q;
	logic [PIX_W-1:0]  knee_q;
	logic [PIX_W-1:0]  lstart_q;
	logic [PIX_W-1:0]  lend_q;
	logic [PIX_W-1:0]  hstart_q;
	logic [PIX_W-1:0]  hend_q;

	// Raster position and the pending horizontal pair.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	pix_t          hold_q;

	// Item in flight through the read and divide steps.
	pix_t                      avg_q;
	logic                      re_q;
	logic                      fe_q;
	logic [CH_N-1:0]           neg_q;
	logic [CH_N-1:0][PIX_W-1:0] base_q;

	// Output register.
	logic out_valid_q;
	pix_t out_pix_q;
	logic out_re_q;
	logic out_fe_q;

	logic [WW-1:0] w_eff;
	logic [HW-1:0] h_eff;
	logic [WW-1:0] col_a;
	logic [HW-1:0] row_a;
	logic [WW-1:0] col_n;
	logic [HW-1:0] row_n;
	logic          row_end_a;
	logic          frame_end_a;

	logic accept;
	logic slot_free;
	logic finish;

	pix_t pix_in;
	pix_t pair_avg;
	pix_t mem_rdata;
	logic mem_en;

	logic [PIX_W-1:0] v_ch    [CH_N];
	logic [PIX_W:0]   v_sum   [CH_N];
	logic [PIX_W-1:0] lo_ch   [CH_N];
	logic [PIX_W-1:0] hi_ch   [CH_N];
	logic [PIX_W-1:0] mul_ch  [CH_N];
	logic [PIX_W-1:0] absd_ch [CH_N];
	logic [PIX_W-1:0] base_ch [CH_N];
	logic             neg_ch  [CH_N];

	curve_op_t        div_op   [CH_N];
	logic [CH_N-1:0]  div_done;
	logic [QUOT_W-1:0] div_quot [CH_N];
	logic             div_start;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_FRAME_WIDTH;
			height_q <= RST_FRAME_HEIGHT;
			knee_q   <= RST_KNEE_LEVEL;
			lstart_q <= RST_LOW_START;
			lend_q   <= RST_LOW_END;
			hstart_q <= RST_HIGH_START;
			hend_q   <= RST_HIGH_END;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_FRAME_WIDTH:  width_q  <= cfg.data;
				REG_FRAME_HEIGHT: height_q <= cfg.data;
				REG_KNEE_LEVEL:   knee_q   <= cfg.data[PIX_W-1:0];
				REG_LOW_START:    lstart_q <= cfg.data[PIX_W-1:0];
				REG_LOW_END:      lend_q   <= cfg.data[PIX_W-1:0];
				REG_HIGH_START:   hstart_q <= cfg.data[PIX_W-1:0];
				REG_HIGH_END:     hend_q   <= cfg.data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	// Frame sizes are clamped to the range the RAM and counters were built for.
	always_comb begin
		if (width_q < MIN_SIZE) begin
			w_eff = WW'(MIN_SIZE);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_eff = WW'(MAX_WIDTH);
		end else begin
			w_eff = WW'(width_q);
		end
		if (height_q < MIN_SIZE) begin
			h_eff = HW'(MIN_SIZE);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_eff = HW'(MAX_HEIGHT);
		end else begin
			h_eff = HW'(height_q);
		end
	end

	// Position of the incoming pixel. The first two checks only fire when the
	// size was lowered in the middle of a frame; then the pixel opens a new row
	// or a new frame.
	always_comb begin
		col_a = WW'(col_q);
		row_a = HW'(row_q);
		if (col_a >= w_eff) begin
			col_a = '0;
			row_a = row_a + 1'b1;
		end
		if (row_a >= h_eff) begin
			row_a = '0;
		end
		col_n = col_a + 1'b1;
		row_n = row_a;
		if (col_n >= w_eff) begin
			col_n = '0;
			row_n = row_a + 1'b1;
			if (row_n >= h_eff) begin
				row_n = '0;
			end
		end
		row_end_a   = (col_a >> 1) == ((w_eff >> 1) - 1'b1);
		frame_end_a = row_end_a && ((row_a >> 1) == ((h_eff >> 1) - 1'b1));
	end

	assign pix_in = {pixel.in_ch2, pixel.in_ch1, pixel.in_ch0};

	always_comb begin
		for (int k = 0; k < CH_N; k++) begin
			pair_avg[k] = 8'((({1'b0, hold_q[k]} + {1'b0, pix_in[k]}) >> 1));
		end
	end

	assign pixel.ready = (state_q == S_IDLE);
	assign accept      = pixel.valid && pixel.ready;

	// Odd columns touch the RAM: even rows write the pair average, odd rows read
	// the average stored from the row above. Reads and writes never overlap
	// because an odd-row item finishes before the next pixel is taken.
	assign mem_en = accept && col_a[0];

	gdtm_line_store #(
		.DEPTH (HALF_DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.en    (mem_en),
		.we    (!row_a[0]),
		.addr  (AW'(col_a >> 1)),
		.wdata (pair_avg),
		.rdata (mem_rdata)
	);

	// Curve operands. Below the knee the low segment is scaled by c/knee; at or
	// above it the high segment by (c-knee)/(255-knee). A knee at full scale
	// gives the high start directly, encoded as a zero dividend.
	always_comb begin
		for (int k = 0; k < CH_N; k++) begin
			v_sum[k] = {1'b0, mem_rdata[k]} + {1'b0, avg_q[k]};
			v_ch[k]  = v_sum[k][PIX_W:1];
			if (v_ch[k] < knee_q) begin
				base_ch[k] = lstart_q;
				lo_ch[k]   = lstart_q;
				hi_ch[k]   = lend_q;
				mul_ch[k]  = v_ch[k];
				div_op[k].den = knee_q;
			end else if (knee_q == PIX_MAX) begin
				base_ch[k] = hstart_q;
				lo_ch[k]   = hstart_q;
				hi_ch[k]   = hstart_q;
				mul_ch[k]  = '0;
				div_op[k].den = 8'd1;
			end else begin
				base_ch[k] = hstart_q;
				lo_ch[k]   = hstart_q;
				hi_ch[k]   = hend_q;
				mul_ch[k]  = v_ch[k] - knee_q;
				div_op[k].den = PIX_MAX - knee_q;
			end
			neg_ch[k]  = hi_ch[k] < lo_ch[k];
			absd_ch[k] = neg_ch[k] ? (lo_ch[k] - hi_ch[k]) : (hi_ch[k] - lo_ch[k]);
			div_op[k].mag = MAG_W'(absd_ch[k]) * MAG_W'(mul_ch[k]);
		end
	end

	assign div_start = (state_q == S_READ);

	for (genvar g = 0; g < CH_N; g++) begin : g_lane
		gdtm_div u_div (
			.clk    (clk),
			.arst_n (arst_n),
			.start  (div_start),
			.op     (div_op[g]),
			.done   (div_done[g]),
			.quot   (div_quot[g])
		);
	end

	assign slot_free = !out_valid_q || result.ready;
	assign finish    = (state_q == S_DIV) && div_done[0] && slot_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			col_q       <= '0;
			row_q       <= '0;
			hold_q      <= '0;
		end else begin
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						col_q <= col_n[CW-1:0];
						row_q <= row_n[RW-1:0];
						if (!col_a[0]) begin
							hold_q <= pix_in;
						end else if (row_a[0]) begin
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_done[0] && slot_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			avg_q <= pair_avg;
			re_q  <= row_end_a;
			fe_q  <= frame_end_a;
		end
		if (div_start) begin
			for (int k = 0; k < CH_N; k++) begin
				neg_q[k]  <= neg_ch[k];
				base_q[k] <= base_ch[k];
			end
		end
		if (finish) begin
			for (int k = 0; k < CH_N; k++) begin
				out_pix_q[k] <= neg_q[k] ? (base_q[k] - div_quot[k])
					: (base_q[k] + div_quot[k]);
			end
			out_re_q <= re_q;
			out_fe_q <= fe_q;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.out_ch0   = out_pix_q[0];
	assign result.out_ch1   = out_pix_q[1];
	assign result.out_ch2   = out_pix_q[2];
	assign result.row_end   = out_re_q;
	assign result.frame_end = out_fe_q;

	// The three divider lanes start together and must finish together.
	assert property (@(posedge clk) disable iff (!arst_n)
		(div_done[0] == div_done[1]) && (div_done[1] == div_done[2]))
		else $error("divider lanes out of step");

	// A finished division is presented on the result port in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		finish |=> result.valid)
		else $error("finished result not presented");

	// The last pixel of a frame is always the last pixel of its row.
	assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (!result.frame_end || result.row_end))
		else $error("frame end without row end");

	// No pixel is taken while an odd-row item is still being read or divided.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_READ) |=> (state_q == S_DIV) && !pixel.ready)
		else $error("pixel taken during a division");

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the 2x2 downsample and tone curve block.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import gdtm_pkg::*;

	localparam int MAX_W       = 1024;
	localparam int MAX_H       = 1024;
	localparam int HALF_N      = MAX_W / 2;
	// Quiet time after draining, long enough that the slowest pixel, a divide, has finished and the block is idle.
	localparam int SETTLE      = 20;
	localparam int STALL_LIMIT = 2000;
	localparam int ITEM_TARGET = 1900;
	// Index 7 is not decoded; writes to it must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

	typedef enum int {STOP_FRAME, STOP_ROW, STOP_COLUMN} stop_mode_t;

	// One half-resolution pixel as the result port presents it.
	typedef struct packed {
		pix_t chans;
		logic row_end;
		logic frame_end;
	} half_px_t;

	// Keeps its own copy of the registers, counters and half-line store, works out
	// the half-resolution pixel each accepted input causes, and checks the results
	// in order against it.
	class downsample_scoreboard;
		logic [SIZE_W-1:0] width_reg;
		logic [SIZE_W-1:0] height_reg;
		logic [PIX_W-1:0]  knee;
		logic [PIX_W-1:0]  low_start;
		logic [PIX_W-1:0]  low_end;
		logic [PIX_W-1:0]  high_start;
		logic [PIX_W-1:0]  high_end;
		int unsigned       col_cnt;
		int unsigned       row_cnt;
		pix_t              pair_hold;
		pix_t              half_line [HALF_N];
		half_px_t          expected_px [$];
		int                fails;

		function new();
			width_reg  = RST_FRAME_WIDTH;
			height_reg = RST_FRAME_HEIGHT;
			knee       = RST_KNEE_LEVEL;
			low_start  = RST_LOW_START;
			low_end    = RST_LOW_END;
			high_start = RST_HIGH_START;
			high_end   = RST_HIGH_END;
			col_cnt    = 0;
			row_cnt    = 0;
			pair_hold  = '0;
			fails      = 0;
		endfunction

		task report(string msg);
			$display("[%0t] MISMATCH: %s", $time, msg);
			fails++;
		endtask

		function int unsigned clamp_size(logic [SIZE_W-1:0] v, int unsigned hi);
			if (v < MIN_SIZE) return MIN_SIZE;
			if (v > hi) return hi;
			return v;
		endfunction

		function int unsigned eff_width();
			return clamp_size(width_reg, MAX_W);
		endfunction

		function int unsigned eff_height();
			return clamp_size(height_reg, MAX_H);
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_FRAME_WIDTH:  width_reg  = data;
			REG_FRAME_HEIGHT: height_reg = data;
			REG_KNEE_LEVEL:   knee       = data[PIX_W-1:0];
			REG_LOW_START:    low_start  = data[PIX_W-1:0];
			REG_LOW_END:      low_end    = data[PIX_W-1:0];
			REG_HIGH_START:   high_start = data[PIX_W-1:0];
			REG_HIGH_END:     high_end   = data[PIX_W-1:0];
			default: ;
			endcase
		endfunction

		// Per-channel (a+b)>>1, dropping the low bit.
		function pix_t box_avg(pix_t a, pix_t b);
			pix_t r;
			for (int k = 0; k < CH_N; k++) begin
				r[k] = PIX_W'((9'(a[k]) + 9'(b[k])) >> 1);
			end
			return r;
		endfunction

		// Two-segment brightness curve; signed int division truncates toward zero,
		// which matters when a segment falls.
		function logic [PIX_W-1:0] tone_curve(logic [PIX_W-1:0] c);
			int t;
			int x;
			int r;
			t = knee;
			x = c;
			if (x < t) begin
				r = int'(low_start) + (int'(low_end) - int'(low_start)) * x / t;
			end else if (t >= int'(PIX_MAX)) begin
				r = high_start;
			end else begin
				r = int'(high_start) + (int'(high_end) - int'(high_start)) * (x - t)
					/ (int'(PIX_MAX) - t);
			end
			return r[PIX_W-1:0];
		endfunction

		function void take_pixel(pix_t p);
			int unsigned w;
			int unsigned h;
			int unsigned col;
			int unsigned row;
			int unsigned idx;
			pix_t        pair;
			pix_t        mixed;
			half_px_t    res;
			w = eff_width();
			h = eff_height();
			// A size that shrank under the counters starts a new row or frame here.
			if (col_cnt >= w) begin
				col_cnt = 0;
				row_cnt++;
			end
			if (row_cnt >= h) row_cnt = 0;
			col = col_cnt;
			row = row_cnt;
			if (col % 2 == 0) begin
				pair_hold = p;
			end else begin
				idx  = (col / 2) % HALF_N;
				pair = box_avg(pair_hold, p);
				if (row % 2 == 0) begin
					half_line[idx] = pair;
				end else begin
					mixed = box_avg(half_line[idx], pair);
					for (int k = 0; k < CH_N; k++) begin
						res.chans[k] = tone_curve(mixed[k]);
					end
					res.row_end   = (col / 2 == w / 2 - 1);
					res.frame_end = res.row_end && (row / 2 == h / 2 - 1);
					expected_px.push_back(res);
				end
			end
			col_cnt = col + 1;
			if (col_cnt >= w) begin
				col_cnt = 0;
				row_cnt = row + 1;
				if (row_cnt >= h) row_cnt = 0;
			end
		endfunction

		task check_pixel(half_px_t got);
			half_px_t want;
			if (expected_px.size() == 0) begin
				report($sformatf("result %h arrived with nothing expected", got));
				return;
			end
			want = expected_px.pop_front();
			for (int k = 0; k < CH_N; k++) begin
				if (got.chans[k] !== want.chans[k]) begin
					report($sformatf("out_ch%0d is %0d, expected %0d", k, got.chans[k],
						want.chans[k]));
				end
			end
			if (got.row_end !== want.row_end) begin
				report($sformatf("row_end is %b, expected %b", got.row_end, want.row_end));
			end
			if (got.frame_end !== want.frame_end) begin
				report($sformatf("frame_end is %b, expected %b", got.frame_end,
					want.frame_end));
			end
		endtask

		function int pending();
			return expected_px.size();
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        steady;
	int unsigned cycle_no = 0;
	int unsigned quiet_cycles = 0;
	int unsigned pixels_sent = 0;
	downsample_scoreboard sb;

	gdtm_pix_if pix_bus ();
	gdtm_res_if res_bus ();
	gdtm_cfg_if cfg_bus ();

	glow_downsample_tone_map #(
		.MAX_WIDTH  (MAX_W),
		.MAX_HEIGHT (MAX_H)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pix_bus),
		.result (res_bus),
		.cfg    (cfg_bus)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// One window of the run where neither side ever idles, so back-to-back
	// transfers meet the long divide of the odd-row pixels.
	assign steady = (cycle_no >= 3000) && (cycle_no < 5000);

	// Cycle count and watchdog: the run is cut off after a long spell in which no
	// transfer happens on any of the three channels.
	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready) ||
			(cfg_bus.valid && cfg_bus.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Result side: check each transfer, then stall at random for the next cycle, except in the steady window.
	always @(posedge clk) begin
		if (arst_n && res_bus.valid && res_bus.ready) begin
			sb.check_pixel({res_bus.out_ch2, res_bus.out_ch1, res_bus.out_ch0,
				res_bus.row_end, res_bus.frame_end});
		end
		res_bus.ready <= steady || ($urandom_range(99) >= 15);
	end

	// Offer one pixel after an optional random gap and wait for its transfer.
	// Valid stays high on return so the next pixel can follow without a bubble.
	task automatic push_pixel(input logic [PIX_W-1:0] c0, c1, c2);
		while (!steady && $urandom_range(99) < 15) begin
			pix_bus.valid <= 1'b0;
			@(posedge clk);
		end
		pix_bus.valid  <= 1'b1;
		pix_bus.in_ch0 <= c0;
		pix_bus.in_ch1 <= c1;
		pix_bus.in_ch2 <= c2;
		@(posedge clk);
		while (!pix_bus.ready) @(posedge clk);
		sb.take_pixel({c2, c1, c0});
		pixels_sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] data);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= data;
		@(posedge clk);
		while (!cfg_bus.ready) @(posedge clk);
		sb.set_reg(idx, data);
	endtask

	// Stop offering pixels, wait for every expected result, then let the block
	// finish any divide that produces nothing before registers may change.
	task automatic wait_drained();
		pix_bus.valid <= 1'b0;
		cfg_bus.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Curve levels and knee, weighted toward the ends of the byte range. The
	// upper bits of the write data are sometimes set; the byte registers drop them.
	function automatic logic [CFG_DATA_W-1:0] level_pick();
		logic [CFG_DATA_W-1:0] v;
		case ($urandom_range(9))
		0: v = 11'd0;
		1: v = 11'd255;
		2: v = 11'd1;
		3: v = 11'd254;
		default: v = CFG_DATA_W'($urandom_range(255));
		endcase
		if ($urandom_range(7) == 0) begin
			v[CFG_DATA_W-1:PIX_W] = (CFG_DATA_W - PIX_W)'($urandom_range(7));
		end
		return v;
	endfunction

	// Frame sizes stay small; 0 and 1 are written now and then to hit the clamp.
	function automatic logic [CFG_DATA_W-1:0] size_pick(int unsigned top);
		case ($urandom_range(19))
		0: return 11'd0;
		1: return 11'd1;
		2: return 11'd2;
		default: return CFG_DATA_W'($urandom_range(2, top));
		endcase
	endfunction

	task automatic retune();
		logic [CFG_IDX_W-1:0] tone_regs [5] = '{REG_KNEE_LEVEL, REG_LOW_START, REG_LOW_END,
			REG_HIGH_START, REG_HIGH_END};
		foreach (tone_regs[i]) begin
			if ($urandom_range(99) < 40) write_reg(tone_regs[i], level_pick());
		end
		if ($urandom_range(99) < 3) write_reg(REG_SPARE, CFG_DATA_W'($urandom));
	endtask

	// Random pixels until the stream reaches the requested stopping point: the end
	// of a frame, the start of an even row, or a given column of an even row.
	// Stopping only there keeps any later size change from reading a line entry
	// that the current frame has not written.
	task automatic stream_pixels(input stop_mode_t mode, input int unsigned stop_col,
		input int unsigned min_items);
		int unsigned n;
		bit          reached;
		n = 0;
		reached = 1'b0;
		while (!reached) begin
			push_pixel(PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
				PIX_W'($urandom_range(255)));
			n++;
			case (mode)
			STOP_FRAME: reached = (sb.col_cnt == 0) && (sb.row_cnt == 0);
			STOP_ROW: reached = (sb.col_cnt == 0) && (sb.row_cnt % 2 == 0) &&
				(n >= min_items);
			default: reached = (sb.col_cnt == stop_col) && (sb.row_cnt % 2 == 0);
			endcase
		end
	endtask

	initial begin
		stop_mode_t  mode;
		int unsigned w;
		int unsigned stop_col;
		int unsigned row_quota;
		int unsigned sel;
		int unsigned phase;
		int unsigned random_base;
		bit          at_frame;
		bit          at_row;
		bit          pinned;
		bit          wide_done;
		bit          tall_done;
		bit          tall_open;

		pix_bus.valid  = 1'b0;
		pix_bus.in_ch0 = '0;
		pix_bus.in_ch1 = '0;
		pix_bus.in_ch2 = '0;
		res_bus.ready  = 1'b0;
		cfg_bus.valid  = 1'b0;
		cfg_bus.index  = '0;
		cfg_bus.data   = '0;
		arst_n = 1'b0;
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Knee at 255, so a full-scale channel maps to the second segment's start.
		// Three rows: the last row is even, so it is taken and stored but never emitted. The
		// undecoded register index is written once with all ones.
		write_reg(REG_FRAME_WIDTH, 11'd4);
		write_reg(REG_FRAME_HEIGHT, 11'd3);
		write_reg(REG_KNEE_LEVEL, 11'd255);
		write_reg(REG_LOW_START, 11'd0);
		write_reg(REG_LOW_END, 11'd255);
		write_reg(REG_HIGH_START, 11'd77);
		write_reg(REG_HIGH_END, 11'd0);
		write_reg(REG_SPARE, 11'h7ff);
		cfg_bus.valid <= 1'b0;
		push_pixel(8'd255, 8'd0, 8'd128);
		push_pixel(8'd255, 8'd0, 8'd127);
		push_pixel(8'd0, 8'd255, 8'd1);
		push_pixel(8'd0, 8'd255, 8'd0);
		push_pixel(8'd255, 8'd0, 8'd126);
		push_pixel(8'd255, 8'd0, 8'd126);
		push_pixel(8'd0, 8'd255, 8'd254);
		push_pixel(8'd1, 8'd254, 8'd255);
		push_pixel(8'd17, 8'd34, 8'd51);
		push_pixel(8'd68, 8'd85, 8'd102);
		push_pixel(8'd119, 8'd136, 8'd153);
		push_pixel(8'd170, 8'd187, 8'd204);
		wait_drained();

		// Knee at 0 puts every level on a falling second segment. An odd width
		// drops the last pixel of each row.
		write_reg(REG_FRAME_WIDTH, 11'd3);
		write_reg(REG_FRAME_HEIGHT, 11'd2);
		write_reg(REG_KNEE_LEVEL, 11'd0);
		write_reg(REG_HIGH_START, 11'd255);
		write_reg(REG_HIGH_END, 11'd0);
		cfg_bus.valid <= 1'b0;
		push_pixel(8'd10, 8'd200, 8'd255);
		push_pixel(8'd20, 8'd100, 8'd0);
		push_pixel(8'd99, 8'd99, 8'd99);
		push_pixel(8'd0, 8'd0, 8'd255);
		push_pixel(8'd255, 8'd255, 8'd255);
		push_pixel(8'd42, 8'd42, 8'd42);
		wait_drained();

		// Sizes below the minimum are clamped to a 2x2 frame; the curve falls from
		// 255 over the first segment and rises over the second.
		write_reg(REG_FRAME_WIDTH, 11'd1);
		write_reg(REG_FRAME_HEIGHT, 11'd0);
		write_reg(REG_KNEE_LEVEL, 11'd1);
		write_reg(REG_LOW_START, 11'd255);
		write_reg(REG_LOW_END, 11'd0);
		write_reg(REG_HIGH_START, 11'd0);
		write_reg(REG_HIGH_END, 11'd255);
		cfg_bus.valid <= 1'b0;
		push_pixel(8'd0, 8'd1, 8'd2);
		push_pixel(8'd1, 8'd0, 8'd255);
		push_pixel(8'd0, 8'd255, 8'd128);
		push_pixel(8'd0, 8'd254, 8'd129);
		wait_drained();

		// Random phases. Each one retunes the curve, perhaps resizes the frame, and
		// streams pixels to a stopping point chosen at random. The single frame at
		// full width counts toward the item budget, so the run ends soon after it.
		phase = 0;
		wide_done = 1'b0;
		tall_done = 1'b0;
		tall_open = 1'b0;
		random_base = pixels_sent;
		while (pixels_sent < random_base + ITEM_TARGET) begin
			retune();
			at_frame = (sb.col_cnt == 0) && (sb.row_cnt == 0);
			at_row = (sb.col_cnt == 0) && (sb.row_cnt % 2 == 0);
			mode = STOP_FRAME;
			row_quota = 0;
			stop_col = 0;
			pinned = 1'b0;
			if (!wide_done && phase >= 6 && at_frame) begin
				// One frame two rows high at the widest line the store can hold.
				write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(MAX_W));
				write_reg(REG_FRAME_HEIGHT, 11'd2);
				wide_done = 1'b1;
				pinned = 1'b1;
			end else if (!tall_done && phase >= 2 && at_frame) begin
				// A height above the limit clamps to the tallest frame. Only part of
				// it is streamed; the next phase cuts it short.
				write_reg(REG_FRAME_WIDTH, 11'd2);
				write_reg(REG_FRAME_HEIGHT, 11'h7ff);
				mode = STOP_ROW;
				row_quota = 40;
				tall_done = 1'b1;
				tall_open = 1'b1;
				pinned = 1'b1;
			end else if (tall_open) begin
				// The row counter is now past the new height, so the next pixel
				// starts a fresh frame.
				write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'($urandom_range(2, 12)));
				tall_open = 1'b0;
			end else if (at_row) begin
				if ($urandom_range(99) < 50) write_reg(REG_FRAME_WIDTH, size_pick(24));
				if ($urandom_range(99) < 50) write_reg(REG_FRAME_HEIGHT, size_pick(10));
			end else if ($urandom_range(99) < 50) begin
				// Part way along an even row: a width no larger than the columns
				// already taken makes the next pixel open the odd row below.
				write_reg(REG_FRAME_WIDTH, CFG_DATA_W'($urandom_range(0, sb.col_cnt)));
			end
			cfg_bus.valid <= 1'b0;

			w = sb.eff_width();
			sel = $urandom_range(99);
			if (!pinned && sel >= 70) begin
				if (sel < 85) begin
					mode = STOP_ROW;
					row_quota = 2 * w;
				end else if (w > 2) begin
					mode = STOP_COLUMN;
					stop_col = $urandom_range(2, w - 1);
				end
			end
			stream_pixels(mode, stop_col, row_quota);
			wait_drained();
			phase++;
		end

		wait_drained();
		if (sb.fails == 0 && sb.pending() == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
